[src/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/kes_pkg.sv]
package kes_pkg;

	localparam logic [7:0] EXIT_KEY = 8'h1D;	// ctrl-]
	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] NUL_BYTE = 8'h00;
	localparam logic [7:0] DEL_BYTE = 8'h7F;

	localparam logic [7:0] SC_NUL   = 8'h03;
	localparam logic [7:0] SC_DEL   = 8'h53;
	localparam logic [7:0] SC_UP    = 8'h48;
	localparam logic [7:0] SC_DOWN  = 8'h50;
	localparam logic [7:0] SC_RIGHT = 8'h4D;
	localparam logic [7:0] SC_LEFT  = 8'h4B;

	localparam logic [7:0] CH_APP = 8'h4F;	// 'O'
	localparam logic [7:0] CH_CSI = 8'h5B;	// '['

	localparam int MAX_RESULTS = 3;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W = $clog2(MAX_RESULTS);

	typedef struct packed {
		logic [CNT_W-1:0] count;	// results for this keystroke, zero for none
		logic             exit_key;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
	} run_t;

	// final letter of the esc [ x sequences, zero for no entry
	function automatic logic [7:0] csi_final(input logic [7:0] scan);
		logic [7:0] f;
		case (scan)
			8'h0F: f = "Z";
			8'h3B: f = "M";
			8'h3C: f = "N";
			8'h3D: f = "O";
			8'h3E: f = "P";
			8'h3F: f = "Q";
			8'h40: f = "R";
			8'h41: f = "S";
			8'h42: f = "T";
			8'h43: f = "U";
			8'h44: f = "V";
			8'h47: f = "H";
			8'h49: f = "I";
			8'h4F: f = "F";
			8'h51: f = "G";
			8'h52: f = "L";
			8'h54: f = "Y";
			8'h55: f = "Z";
			8'h56: f = "a";
			8'h57: f = "b";
			8'h58: f = "c";
			8'h59: f = "d";
			8'h5A: f = "e";
			8'h5B: f = "f";
			8'h5C: f = "g";
			8'h5D: f = "h";
			8'h5E: f = "k";
			8'h5F: f = "l";
			8'h60: f = "m";
			8'h61: f = "n";
			8'h62: f = "o";
			8'h63: f = "p";
			8'h64: f = "q";
			8'h65: f = "r";
			8'h66: f = "s";
			8'h67: f = "t";
			8'h68: f = "w";
			8'h69: f = "x";
			8'h6A: f = "y";
			8'h6B: f = "z";
			8'h6C: f = "@";
			8'h6D: f = "[";
			8'h6E: f = 8'h5C;
			8'h6F: f = "]";
			8'h70: f = "^";
			8'h71: f = "_";
			default: f = 8'h00;
		endcase
		return f;
	endfunction

endpackage

[src/kes_key_if.sv]
interface kes_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_code;
	logic [7:0] scan_code;
	logic       app_cursor_mode;

	modport source (output valid, output ascii_code, output scan_code,
		output app_cursor_mode, input ready);
	modport sink (input valid, input ascii_code, input scan_code,
		input app_cursor_mode, output ready);
endinterface

[src/kes_seq_if.sv]
interface kes_seq_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       exit_request;
	logic       last_of_run;

	modport source (output valid, output out_byte, output byte_valid,
		output exit_request, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input exit_request, input last_of_run, output ready);
endinterface

[src/kes_decode.sv]
module kes_decode
	import kes_pkg::*;
(
	input  logic [7:0] ascii_code,
	input  logic [7:0] scan_code,
	input  logic       app_cursor_mode,
	output run_t       run
);

	logic [7:0] fin;

	assign fin = csi_final(scan_code);

	always_comb begin
		run = '0;
		if (ascii_code != 8'h00) begin
			run.count = CNT_W'(1);
			if (ascii_code == EXIT_KEY) begin
				run.exit_key = 1'b1;
			end else begin
				run.b0 = ascii_code;
			end
		end else begin
			case (scan_code)
				SC_NUL: begin
					run.count = CNT_W'(1);
					run.b0    = NUL_BYTE;
				end
				SC_DEL: begin
					run.count = CNT_W'(1);
					run.b0    = DEL_BYTE;
				end
				SC_UP, SC_DOWN, SC_RIGHT, SC_LEFT: begin
					run.count = CNT_W'(3);
					run.b0    = ESC_BYTE;
					run.b1    = app_cursor_mode ? CH_APP : CH_CSI;
					case (scan_code)
						SC_UP:    run.b2 = "A";
						SC_DOWN:  run.b2 = "B";
						SC_RIGHT: run.b2 = "C";
						default:  run.b2 = "D";
					endcase
				end
				default: begin
					// unknown scan codes leave count at zero
					if (fin != 8'h00) begin
						run.count = CNT_W'(3);
						run.b0    = ESC_BYTE;
						run.b1    = CH_CSI;
						run.b2    = fin;
					end
				end
			endcase
		end
	end

endmodule

[src/kes_serializer.sv]
`include "assert_macros.svh"

module kes_serializer
	import kes_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  run_t      run_d,
	kes_key_if.sink   key,
	kes_seq_if.source seq
);

	run_t             run_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             last;
	logic             take;
	logic             load;

	assign last = CNT_W'(idx_q) == run_q.count - CNT_W'(1);
	assign take = busy_q && seq.ready;
	// next keystroke enters in the cycle the last result leaves
	assign key.ready = !busy_q || (take && last);
	assign load = key.valid && key.ready && (run_d.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (take && last) begin
				busy_q <= 1'b0;
			end else if (take) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run_d;
		end
	end

	always_comb begin
		case (idx_q)
			IDX_W'(0): seq.out_byte = run_q.b0;
			IDX_W'(1): seq.out_byte = run_q.b1;
			default:   seq.out_byte = run_q.b2;
		endcase
	end

	assign seq.valid        = busy_q;
	assign seq.byte_valid   = !run_q.exit_key;
	assign seq.exit_request = run_q.exit_key;
	assign seq.last_of_run  = last;

	`ASSERT_IMPLIES(a_idx_in_run, clk, arst_n, busy_q, CNT_W'(idx_q) < run_q.count)
	`ASSERT_IMPLIES(a_exit_single, clk, arst_n, busy_q && run_q.exit_key,
		run_q.count == CNT_W'(1))
	`ASSERT_IMPLIES(a_accept_on_last, clk, arst_n, busy_q && key.ready,
		seq.ready && last)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, seq.valid && !seq.ready,
		seq.valid && $stable(idx_q))

endmodule

[src/key_to_escape_sequence.sv]
// Encodes one PC keystroke per item on key into zero to three result items on
// seq. Each accepted keystroke is decoded in the accept cycle into a run
// register; its results then leave that register one per cycle while seq is
// ready, the first offered in the cycle after acceptance. The next keystroke is
// taken in the cycle the last result of the current run is taken, so with seq
// always ready runs follow one another with no idle gap; a keystroke with an
// unknown scan code gives no result and leaves the run register idle.
// The run register, one result per cycle while seq is ready, sets the rate.
module key_to_escape_sequence
	import kes_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	kes_key_if.sink   key,
	kes_seq_if.source seq
);

	run_t run_d;

	kes_decode u_decode (
		.ascii_code      (key.ascii_code),
		.scan_code       (key.scan_code),
		.app_cursor_mode (key.app_cursor_mode),
		.run             (run_d)
	);

	kes_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.run_d  (run_d),
		.key    (key),
		.seq    (seq)
	);

endmodule

[test/key_to_escape_sequence_tb.sv]
module key_to_escape_sequence_tb;
	import kes_pkg::*;

	localparam int N_DIR         = 24;
	localparam int N_RANDOM_KEYS = 396;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_SHOWN     = 10;
	localparam int PREDICT       = -1;	// row is checked against the encoder model

	localparam logic [7:0] FIN_UP    = "A";
	localparam logic [7:0] FIN_DOWN  = "B";
	localparam logic [7:0] FIN_RIGHT = "C";
	localparam logic [7:0] FIN_LEFT  = "D";

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       exit_request;
		logic       last_of_run;
	} seq_item_t;

	typedef struct {
		logic [7:0] ascii;
		logic [7:0] scan;
		logic       app;
		int         typed_n;	// results typed in, or PREDICT
		logic [7:0] typed_byte;
		logic       typed_exit;
	} key_row_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_TOGGLE, RX_SLOW} rx_mode_t;

	logic clk;
	logic arst_n;

	kes_key_if key_ch ();
	kes_seq_if seq_ch ();

	key_to_escape_sequence dut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch.sink),
		.seq    (seq_ch.source)
	);

	logic [7:0] csi_letter [0:255];
	logic [7:0] known_scans [$];
	seq_item_t  expected_seq [$];
	seq_item_t  got, want;
	key_row_t   cur_row;
	rx_mode_t   rx_mode;
	int         rx_left;
	int         burst_left;
	int         errors;
	int         cycles;
	int         n_keys, n_silent, n_results, n_exits, n_esc_runs;

	key_row_t dir_rows [N_DIR] = '{
		'{8'hFF,    8'h00,    1'b0, 1,       8'hFF,    1'b0},
		'{8'h01,    8'hFF,    1'b1, 1,       8'h01,    1'b0},	// scan code ignored
		'{8'h80,    SC_DEL,   1'b0, 1,       8'h80,    1'b0},
		'{ESC_BYTE, 8'h00,    1'b1, 1,       ESC_BYTE, 1'b0},
		'{8'h7F,    SC_UP,    1'b1, 1,       8'h7F,    1'b0},
		'{EXIT_KEY, SC_UP,    1'b1, 1,       8'h00,    1'b1},
		'{EXIT_KEY, 8'h00,    1'b0, 1,       8'h00,    1'b1},
		'{8'h00,    8'h00,    1'b0, 0,       8'h00,    1'b0},	// unknown scan codes: silent
		'{8'h00,    8'hFF,    1'b1, 0,       8'h00,    1'b0},
		'{8'h00,    8'h01,    1'b0, 0,       8'h00,    1'b0},
		'{8'h00,    SC_NUL,   1'b0, 1,       NUL_BYTE, 1'b0},
		'{8'h00,    SC_DEL,   1'b1, 1,       DEL_BYTE, 1'b0},
		'{8'h00,    SC_UP,    1'b1, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_DOWN,  1'b1, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_RIGHT, 1'b1, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_LEFT,  1'b1, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_UP,    1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_DOWN,  1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_RIGHT, 1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    SC_LEFT,  1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    8'h0F,    1'b1, PREDICT, 8'h00,    1'b0},
		'{8'h00,    8'h71,    1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    8'h6E,    1'b0, PREDICT, 8'h00,    1'b0},
		'{8'h00,    8'h4F,    1'b1, PREDICT, 8'h00,    1'b0}	// not an arrow, mode ignored
	};

	// final letters of the esc [ x sequences
	initial begin
		foreach (csi_letter[i])
			csi_letter[i] = 8'h00;
		csi_letter[8'h0F] = "Z";
		csi_letter[8'h3B] = "M"; csi_letter[8'h3C] = "N"; csi_letter[8'h3D] = "O";
		csi_letter[8'h3E] = "P"; csi_letter[8'h3F] = "Q"; csi_letter[8'h40] = "R";
		csi_letter[8'h41] = "S"; csi_letter[8'h42] = "T"; csi_letter[8'h43] = "U";
		csi_letter[8'h44] = "V"; csi_letter[8'h47] = "H"; csi_letter[8'h49] = "I";
		csi_letter[8'h4F] = "F"; csi_letter[8'h51] = "G"; csi_letter[8'h52] = "L";
		csi_letter[8'h54] = "Y"; csi_letter[8'h55] = "Z"; csi_letter[8'h56] = "a";
		csi_letter[8'h57] = "b"; csi_letter[8'h58] = "c"; csi_letter[8'h59] = "d";
		csi_letter[8'h5A] = "e"; csi_letter[8'h5B] = "f"; csi_letter[8'h5C] = "g";
		csi_letter[8'h5D] = "h"; csi_letter[8'h5E] = "k"; csi_letter[8'h5F] = "l";
		csi_letter[8'h60] = "m"; csi_letter[8'h61] = "n"; csi_letter[8'h62] = "o";
		csi_letter[8'h63] = "p"; csi_letter[8'h64] = "q"; csi_letter[8'h65] = "r";
		csi_letter[8'h66] = "s"; csi_letter[8'h67] = "t"; csi_letter[8'h68] = "w";
		csi_letter[8'h69] = "x"; csi_letter[8'h6A] = "y"; csi_letter[8'h6B] = "z";
		csi_letter[8'h6C] = "@"; csi_letter[8'h6D] = "["; csi_letter[8'h6E] = 8'h5C;
		csi_letter[8'h6F] = "]"; csi_letter[8'h70] = "^"; csi_letter[8'h71] = "_";
	end

	// bytes sent for one keystroke, appended to runs
	function automatic void encode_key(input logic [7:0] ascii, input logic [7:0] scan,
			input logic app, ref seq_item_t runs[$]);
		logic [7:0] mid;
		logic [7:0] fin;
		if (ascii != 8'h00) begin
			if (ascii == EXIT_KEY)
				runs.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
			else
				runs.push_back('{ascii, 1'b1, 1'b0, 1'b1});
			return;
		end
		mid = CH_CSI;
		fin = csi_letter[scan];
		case (scan)
			SC_NUL: begin
				runs.push_back('{NUL_BYTE, 1'b1, 1'b0, 1'b1});
				return;
			end
			SC_DEL: begin
				runs.push_back('{DEL_BYTE, 1'b1, 1'b0, 1'b1});
				return;
			end
			SC_UP:    fin = FIN_UP;
			SC_DOWN:  fin = FIN_DOWN;
			SC_RIGHT: fin = FIN_RIGHT;
			SC_LEFT:  fin = FIN_LEFT;
			default: ;
		endcase
		if (scan == SC_UP || scan == SC_DOWN || scan == SC_RIGHT || scan == SC_LEFT)
			mid = app ? CH_APP : CH_CSI;
		if (fin != 8'h00) begin
			runs.push_back('{ESC_BYTE, 1'b1, 1'b0, 1'b0});
			runs.push_back('{mid, 1'b1, 1'b0, 1'b0});
			runs.push_back('{fin, 1'b1, 1'b0, 1'b1});
		end
	endfunction

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("mismatch: %s", msg);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: ready pattern switches at random between always, random, toggle and slow modes
	initial begin
		seq_ch.ready = 1'b0;
		rx_mode = RX_ALWAYS;
		rx_left = 0;
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS: seq_ch.ready <= 1'b1;
			RX_RANDOM: seq_ch.ready <= ($urandom_range(0, 2) != 0);
			RX_TOGGLE: seq_ch.ready <= ~seq_ch.ready;
			RX_SLOW:   seq_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// predict on accepted keys, check accepted results
	always @(posedge clk) begin
		if (arst_n && key_ch.valid && key_ch.ready) begin
			int before_n;
			before_n = expected_seq.size();
			if (cur_row.typed_n == PREDICT)
				encode_key(key_ch.ascii_code, key_ch.scan_code, key_ch.app_cursor_mode,
					expected_seq);
			else if (cur_row.typed_n == 1)
				expected_seq.push_back('{cur_row.typed_byte, ~cur_row.typed_exit,
					cur_row.typed_exit, 1'b1});
			n_keys++;
			if (expected_seq.size() == before_n)
				n_silent++;
			if (expected_seq.size() == before_n + 3)
				n_esc_runs++;
		end
		if (arst_n && seq_ch.valid && seq_ch.ready) begin
			got = '{seq_ch.out_byte, seq_ch.byte_valid, seq_ch.exit_request,
				seq_ch.last_of_run};
			n_results++;
			if (got.exit_request === 1'b1)
				n_exits++;
			if (expected_seq.size() == 0) begin
				note_error($sformatf("unexpected item byte=%h valid=%b exit=%b last=%b",
					got.out_byte, got.byte_valid, got.exit_request, got.last_of_run));
			end else begin
				want = expected_seq.pop_front();
				if (got !== want)
					note_error($sformatf(
						"byte %h/%h valid %b/%b exit %b/%b last %b/%b (expected/actual)",
						want.out_byte, got.out_byte, want.byte_valid, got.byte_valid,
						want.exit_request, got.exit_request, want.last_of_run,
						got.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding", cycles,
				expected_seq.size());
			$display("key_to_escape_sequence_tb NOT OK");
			$finish;
		end
	end

	// sender: bursts of random length, random gaps with junk on the fields
	task automatic put_key(input key_row_t row);
		int gap;
		key_ch.valid <= 1'b1;
		key_ch.ascii_code <= row.ascii;
		key_ch.scan_code <= row.scan;
		key_ch.app_cursor_mode <= row.app;
		cur_row <= row;
		do
			@(posedge clk);
		while (key_ch.ready !== 1'b1);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				key_ch.valid <= 1'b0;
				key_ch.ascii_code <= 8'($urandom);
				key_ch.scan_code <= 8'($urandom);
				key_ch.app_cursor_mode <= 1'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		key_row_t  row;
		int        pick;
		arst_n = 1'b0;
		key_ch.valid = 1'b0;
		key_ch.ascii_code = 8'h00;
		key_ch.scan_code = 8'h00;
		key_ch.app_cursor_mode = 1'b0;
		cur_row = '{8'h00, 8'h00, 1'b0, PREDICT, 8'h00, 1'b0};
		errors = 0;
		cycles = 0;
		burst_left = 0;
		n_keys = 0;
		n_silent = 0;
		n_results = 0;
		n_exits = 0;
		n_esc_runs = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 256; i++)
			if (csi_letter[i] != 8'h00)
				known_scans.push_back(i[7:0]);
		known_scans.push_back(SC_UP);
		known_scans.push_back(SC_DOWN);
		known_scans.push_back(SC_RIGHT);
		known_scans.push_back(SC_LEFT);
		known_scans.push_back(SC_NUL);
		known_scans.push_back(SC_DEL);

		foreach (dir_rows[i])
			put_key(dir_rows[i]);

		// extended keys with a table entry in 45 of 100 picks, the rest random scan codes, exit keys and random bytes
		for (int k = 0; k < N_RANDOM_KEYS; k++) begin
			pick = $urandom_range(0, 99);
			row.app = 1'($urandom);
			row.scan = 8'($urandom);
			row.typed_n = PREDICT;
			row.typed_byte = 8'h00;
			row.typed_exit = 1'b0;
			if (pick < 45) begin
				row.ascii = 8'h00;
				row.scan = known_scans[$urandom_range(0, known_scans.size() - 1)];
			end else if (pick < 55) begin
				row.ascii = 8'h00;
			end else if (pick < 62) begin
				row.ascii = EXIT_KEY;
			end else begin
				row.ascii = 8'($urandom);
			end
			put_key(row);
		end
		key_ch.valid <= 1'b0;

		// let the last accepted key reach the prediction queue
		@(posedge clk);
		while (expected_seq.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d keystrokes sent (%0d silent, %0d escape sequences), %0d items checked",
			n_keys, n_silent, n_esc_runs, n_results);
		$display("%0d exit requests seen, %0d mismatches", n_exits, errors);
		if (errors == 0)
			$display("key_to_escape_sequence_tb OK");
		else
			$display("key_to_escape_sequence_tb NOT OK");
		$finish;
	end

endmodule
